>>> src/ghp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghp_pkg
// Shared types and constants of the generational handle pool.
// ----------------------------------------------------------------------------
package ghp_pkg;

   localparam int SLOTS  = 1024;
   localparam int IDX_W  = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);

   // fixed field widths of the stream items
   localparam int HIDX_W = 10;
   localparam int GEN_W  = 32;
   localparam int WORD_W = 32;
   localparam int PAY_W  = 2 * WORD_W;
   localparam int LEFT_W = 11;
   localparam int STAT_W = 2;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 56;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 2'd0,
      ST_EMPTY      = 2'd1,
      ST_BAD_HANDLE = 2'd2
   } status_type;

   // requests to the free stack
   typedef struct packed {
      logic             rd_en;     // read entry at top - 1
      logic             pop;       // commit the pop: top - 1
      logic             push;      // write push_idx at top, top + 1
      logic [IDX_W-1:0] push_idx;
   } stk_req_type;

   // requests to the slot memories
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic             wr_active;
      logic [GEN_W-1:0] wr_gen;
      logic             pay_en;
      logic [PAY_W-1:0] pay;
   } slot_req_type;

endpackage : ghp_pkg
`default_nettype wire

>>> src/ghp_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghp_stack
// Free-index stack in a synchronous memory, with top and low-water counts.
// ----------------------------------------------------------------------------
module ghp_stack (
   input  logic                clock,
   input  logic                reset,
   input  ghp_pkg::stk_req_type req,
   output logic [ghp_pkg::CNT_W-1:0] top,
   output logic [ghp_pkg::IDX_W-1:0] pop_idx
);
   import ghp_pkg::*;

   logic [IDX_W-1:0] stk_mem [SLOTS];
   logic [IDX_W-1:0] mem_q_ff;
   logic [IDX_W-1:0] rd_pos_ff, rd_pos_in;
   logic             rd_written_ff, rd_written_in;
   logic [CNT_W-1:0] top_ff, top_in;
   // lowest top ever reached: entries at or above it were written since reset
   logic [CNT_W-1:0] low_ff, low_in;
   logic [CNT_W-1:0] top_dec;
   logic [CNT_W-1:0] rst_val;

   assign top_dec       = top_ff - CNT_W'(1);
   assign rd_pos_in     = top_dec[IDX_W-1:0];
   assign rd_written_in = (top_dec >= low_ff);

   always_comb begin
      top_in = top_ff;
      low_in = low_ff;
      if (req.pop) begin
         top_in = top_dec;
         if (top_dec < low_ff) begin
            low_in = top_dec;
         end
      end else if (req.push) begin
         top_in = top_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= CNT_W'(SLOTS);
         low_ff <= CNT_W'(SLOTS);
      end else begin
         top_ff <= top_in;
         low_ff <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.push) begin
         stk_mem[top_ff[IDX_W-1:0]] <= req.push_idx;
      end
      if (req.rd_en) begin
         mem_q_ff      <= stk_mem[rd_pos_in];
         rd_pos_ff     <= rd_pos_in;
         rd_written_ff <= rd_written_in;
      end
   end

   // an entry never written holds its reset index SLOTS-1-pos
   assign rst_val = CNT_W'(SLOTS - 1) - CNT_W'(rd_pos_ff);
   assign pop_idx = rd_written_ff ? mem_q_ff : rst_val[IDX_W-1:0];
   assign top     = top_ff;

endmodule : ghp_stack
`default_nettype wire

>>> src/ghp_slots.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghp_slots
// Slot state memory (active flag, generation) with clearing pass, and
// payload memory.
// ----------------------------------------------------------------------------
module ghp_slots (
   input  logic                          clock,
   input  logic                          reset,
   input  ghp_pkg::slot_req_type         req,
   output logic                          clr_busy,
   output logic                          rd_active,
   output logic [ghp_pkg::GEN_W-1:0]     rd_gen
);
   import ghp_pkg::*;

   logic [GEN_W:0]   slot_mem [SLOTS];
   logic [PAY_W-1:0] pay_mem  [SLOTS];
   logic [GEN_W:0]   rd_q_ff;
   logic             clr_ff, clr_in;
   logic [CNT_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [GEN_W:0]   wr_data;

   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + CNT_W'(1);
         if (clr_cnt_ff == CNT_W'(SLOTS - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // clearing pass owns the write port: inactive, generation one
   assign wr_en   = clr_ff | req.wr_en;
   assign wr_idx  = clr_ff ? clr_cnt_ff[IDX_W-1:0] : req.wr_idx;
   assign wr_data = clr_ff ? {1'b0, GEN_W'(1)} : {req.wr_active, req.wr_gen};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_idx] <= wr_data;
      end
      if (req.rd_en) begin
         rd_q_ff <= slot_mem[req.rd_idx];
      end
      if (req.pay_en) begin
         pay_mem[req.wr_idx] <= req.pay;
      end
   end

   assign clr_busy  = clr_ff;
   assign rd_active = rd_q_ff[GEN_W];
   assign rd_gen    = rd_q_ff[GEN_W-1:0];

endmodule : ghp_slots
`default_nettype wire

>>> src/generational_handle_pool.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_pool
// Fixed pool of slots handed out as handles (index, generation).
//
// Request channel (req_*): one item per operation. tuser carries func
// (0 alloc, 1 free); tdata carries payload_x, payload_y, handle_index and
// handle_generation. Response channel (rsp_*): exactly one item per request,
// in order, with slot_index, slot_generation, status and free_slots_left.
// Alloc pops a free index, stores the payload, marks the slot active and
// returns its generation. Free checks the handle (active, matching
// generation), clears the slot, bumps its generation and pushes the index.
// Alloc on an empty pool reports status 1; a bad or stale free reports 2.
// Alloc runs the stack read, then the slot read, then the update; free
// skips the stack read and empty alloc skips both reads. One item is in
// work at a time, so a new request waits until the last one has left its
// final step; the dependent stack-then-slot memory reads set this.
// After reset a clearing pass sets every generation to one and every
// slot inactive; req_tready stays low until it ends.
// The response sits in an output register; a new request is accepted
// while it waits. If the receiver stalls, the next item holds in its
// final step, with no state written, until the response register frees.
// ----------------------------------------------------------------------------
module generational_handle_pool (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // payload_x[31:0], payload_y[63:32], handle_index[73:64],
   // handle_generation[105:74], zero fill[111:106]
   input  logic [ghp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // func[0]
   input  logic                            req_tuser,
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // slot_index[9:0], slot_generation[41:10], status[43:42],
   // free_slots_left[54:44], zero fill[55]
   output logic [ghp_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ghp_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_POP,
      S_FIN
   } state_type;

   state_type         state_ff, state_in;
   func_type          func_ff, func_in;
   logic [PAY_W-1:0]  pay_ff, pay_in;
   logic [HIDX_W-1:0] hidx_ff, hidx_in;
   logic [GEN_W-1:0]  hgen_ff, hgen_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              empty_ff, empty_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   stk_req_type       stk_req;
   slot_req_type      slot_req;
   logic [CNT_W-1:0]  top;
   logic [IDX_W-1:0]  pop_idx;
   logic              clr_busy;
   logic              rd_active;
   logic [GEN_W-1:0]  rd_gen;

   logic              req_acc;
   logic              out_free;
   logic              free_bad;
   logic [GEN_W-1:0]  gen_inc;
   logic [HIDX_W-1:0] res_idx;
   logic [GEN_W-1:0]  res_gen;
   status_type        res_stat;
   logic [CNT_W-1:0]  res_left;

   ghp_stack u_stack (
      .clock   (clock),
      .reset   (reset),
      .req     (stk_req),
      .top     (top),
      .pop_idx (pop_idx)
   );

   ghp_slots u_slots (
      .clock     (clock),
      .reset     (reset),
      .req       (slot_req),
      .clr_busy  (clr_busy),
      .rd_active (rd_active),
      .rd_gen    (rd_gen)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign gen_inc    = rd_gen + GEN_W'(1);
   assign free_bad   = (32'(hidx_ff) >= 32'(SLOTS)) | ~rd_active |
                       (rd_gen != hgen_ff) | (top >= CNT_W'(SLOTS));

   // result of the item in its final step
   always_comb begin
      res_idx  = '0;
      res_gen  = '0;
      res_stat = ST_OK;
      res_left = top;
      if (func_ff == FUNC_ALLOC) begin
         if (empty_ff) begin
            res_stat = ST_EMPTY;
         end else begin
            res_idx  = HIDX_W'(idx_ff);
            res_gen  = rd_gen;
            res_left = top - CNT_W'(1);
         end
      end else begin
         res_idx = hidx_ff;
         if (free_bad) begin
            res_stat = ST_BAD_HANDLE;
         end else begin
            res_gen  = gen_inc;
            res_left = top + CNT_W'(1);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      pay_in       = pay_ff;
      hidx_in      = hidx_ff;
      hgen_in      = hgen_ff;
      idx_in       = idx_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      stk_req      = '0;
      slot_req     = '0;
      unique case (state_ff)
         S_CLEAR: begin
            if (!clr_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               func_in  = func_type'(req_tuser);
               pay_in   = req_tdata[PAY_W-1:0];
               hidx_in  = req_tdata[PAY_W +: HIDX_W];
               hgen_in  = req_tdata[PAY_W + HIDX_W +: GEN_W];
               empty_in = (top == '0);
               idx_in   = IDX_W'(req_tdata[PAY_W +: HIDX_W]);
               if (func_type'(req_tuser) == FUNC_FREE) begin
                  // read the handle's slot
                  slot_req.rd_en  = 1'b1;
                  slot_req.rd_idx = IDX_W'(req_tdata[PAY_W +: HIDX_W]);
                  state_in        = S_FIN;
               end else if (top == '0) begin
                  state_in = S_FIN;
               end else begin
                  stk_req.rd_en = 1'b1;
                  state_in      = S_POP;
               end
            end
         end
         S_POP: begin
            // stack entry ready: read the popped slot
            idx_in          = pop_idx;
            slot_req.rd_en  = 1'b1;
            slot_req.rd_idx = pop_idx;
            state_in        = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, LEFT_W'(res_left), res_stat, res_gen, res_idx};
               state_in     = S_IDLE;
               if (func_ff == FUNC_ALLOC) begin
                  if (!empty_ff) begin
                     stk_req.pop        = 1'b1;
                     slot_req.wr_en     = 1'b1;
                     slot_req.wr_idx    = idx_ff;
                     slot_req.wr_active = 1'b1;
                     slot_req.wr_gen    = rd_gen;
                     slot_req.pay_en    = 1'b1;
                     slot_req.pay       = pay_ff;
                  end
               end else if (!free_bad) begin
                  stk_req.push       = 1'b1;
                  stk_req.push_idx   = idx_ff;
                  slot_req.wr_en     = 1'b1;
                  slot_req.wr_idx    = idx_ff;
                  slot_req.wr_active = 1'b0;
                  slot_req.wr_gen    = gen_inc;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold item fields and the response payload
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      pay_ff      <= pay_in;
      hidx_ff     <= hidx_in;
      hgen_ff     <= hgen_in;
      idx_ff      <= idx_in;
      empty_ff    <= empty_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule : generational_handle_pool
`default_nettype wire
